FILE: hdl/fm_quadrature_discriminator_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the FM quadrature discriminator
// Concurrent assertion wrappers that drop out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef FM_QUADRATURE_DISCRIMINATOR_UNIT_MACROS_SVH
`define FM_QUADRATURE_DISCRIMINATOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define FMQD_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define FMQD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define FMQD_ASSERT(lbl, clk, rst_n, prop, msg)
`define FMQD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: hdl/fmqd_pkg.sv
// ----------------------------------------------------------------------------
// FM quadrature discriminator package
// Types, command and status structs and fixed-point constants.
// ----------------------------------------------------------------------------
package fmqd_pkg;

	localparam int DIV_W = 48;
	localparam int DIV_CNT_W = 6;

	localparam logic [31:0] GAIN_RESET = 32'h7FFF_0000;
	localparam logic [15:0] ATAN_K_Q16 = 16'd18406;
	localparam logic [16:0] HALF_PI_Q16 = 17'd102944;
	localparam logic [47:0] ONE_Q16 = 48'd65536;
	localparam logic [31:0] X_POS_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] X_NEG_MAX = 32'h8000_0000;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_SUM,
		ST_CHK,
		ST_DIVX,
		ST_XSAT,
		ST_SQR,
		ST_KX,
		ST_LDA,
		ST_DIVA,
		ST_ANG,
		ST_SCALE,
		ST_OUT
	} fmqd_state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_MUL,
		OP_SUM,
		OP_DIVX,
		OP_XSAT,
		OP_SQR,
		OP_KX,
		OP_DIVA,
		OP_ANG,
		OP_HALFPI,
		OP_SCALE,
		OP_OUT
	} fmqd_op_t;

	typedef struct packed {
		fmqd_op_t op;
	} fmqd_cmd_t;

	typedef struct packed {
		logic re_zero;
		logic div_done;
		logic out_free;
	} fmqd_status_t;

endpackage

FILE: hdl/fmqd_if.sv
// ----------------------------------------------------------------------------
// FM quadrature discriminator channel interfaces
// Valid/ready channels for samples, results and the gain register write.
// ----------------------------------------------------------------------------
interface fmqd_in_if;
	logic valid;
	logic ready;
	logic signed [15:0] sample_i;
	logic signed [15:0] sample_q;
	modport source(output valid, output sample_i, output sample_q, input ready);
	modport sink(input valid, input sample_i, input sample_q, output ready);
endinterface

interface fmqd_out_if;
	logic valid;
	logic ready;
	logic signed [15:0] demod_value;
	modport source(output valid, output demod_value, input ready);
	modport sink(input valid, input demod_value, output ready);
endinterface

interface fmqd_cfg_if;
	logic valid;
	logic ready;
	logic [31:0] output_gain;
	modport source(output valid, output output_gain, input ready);
	modport sink(input valid, input output_gain, output ready);
endinterface

FILE: hdl/fmqd_div.sv
// ----------------------------------------------------------------------------
// FM quadrature discriminator divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`include "fm_quadrature_discriminator_unit_macros.svh"

module fmqd_div import fmqd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] num,
	input  logic [DIV_W-1:0] den,
	output logic             done,
	output logic [DIV_W-1:0] quo
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0]     rem_q;
	logic [DIV_W-1:0]     quo_q;
	logic [DIV_W-1:0]     den_q;
	logic [DIV_W:0]       shifted;
	logic [DIV_W+1:0]     diff;
	logic                 take;

	assign shifted = {rem_q, quo_q[DIV_W-1]};
	assign diff = {1'b0, shifted} - {2'b00, den_q};
	assign take = ~diff[DIV_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= take ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], take};
		end
	end

	assign done = done_q;
	assign quo = quo_q;

	`FMQD_ASSERT(a_no_restart, clk, arst_n, start |-> !busy_q, "divider started while busy")
	`FMQD_ASSERT_NEXT(a_start_busy, clk, arst_n, start, busy_q && !done_q, "divider did not start")
	`FMQD_ASSERT(a_done_idle, clk, arst_n, done_q |-> !busy_q, "divider done while busy")

endmodule

FILE: hdl/fmqd_dp.sv
// ----------------------------------------------------------------------------
// FM quadrature discriminator datapath
// Conjugate product, ratio, arctangent approximation, gain and saturation.
// ----------------------------------------------------------------------------
module fmqd_dp import fmqd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  fmqd_cmd_t           cmd,
	output fmqd_status_t        status,
	input  logic signed [15:0]  sample_i,
	input  logic signed [15:0]  sample_q,
	input  logic                gain_we,
	input  logic [31:0]         gain_data,
	input  logic                out_ready,
	output logic                out_valid,
	output logic signed [15:0]  demod_value
);

	logic signed [15:0] cur_i_q;
	logic signed [15:0] cur_q_q;
	logic signed [15:0] prev_i_q;
	logic signed [15:0] prev_q_q;
	logic signed [31:0] p_ii_q;
	logic signed [31:0] p_qq_q;
	logic signed [31:0] p_qi_q;
	logic signed [31:0] p_iq_q;
	logic [31:0]        re_q;
	logic [31:0]        im_q;
	logic [31:0]        gain_q;
	logic               x_sign_q;
	logic [31:0]        x_mag_q;
	logic               x_neg_q;
	logic [63:0]        sq_q;
	logic [63:0]        kx_q;
	logic [16:0]        ang_mag_q;
	logic               ang_neg_q;
	logic [48:0]        scl_q;
	logic               out_valid_q;
	logic signed [15:0] out_data_q;

	logic [31:0]        re_abs;
	logic [31:0]        im_abs;
	logic [31:0]        x_limit;
	logic               div_start;
	logic [DIV_W-1:0]   div_num;
	logic [DIV_W-1:0]   div_den;
	logic               div_done;
	logic [DIV_W-1:0]   div_quo;
	logic [16:0]        scaled;
	logic signed [15:0] sat_val;
	logic               out_free;

	assign re_abs = re_q[31] ? (~re_q + 32'd1) : re_q;
	assign im_abs = im_q[31] ? (~im_q + 32'd1) : im_q;
	assign x_limit = x_sign_q ? X_NEG_MAX : X_POS_MAX;
	assign scaled = scl_q[48:32];
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		div_start = 1'b0;
		div_num = {im_abs, 16'h0000};
		div_den = {16'h0000, re_abs};
		if (cmd.op == OP_DIVX) begin
			div_start = 1'b1;
		end else if (cmd.op == OP_DIVA) begin
			div_start = 1'b1;
			div_num = {x_mag_q, 16'h0000};
			div_den = ONE_Q16 + kx_q[63:16];
		end
	end

	always_comb begin
		if (ang_neg_q) begin
			sat_val = (scaled > 17'd32768) ? -16'sd32768 : 16'(~scaled + 17'd1);
		end else begin
			sat_val = (scaled > 17'd32767) ? 16'sd32767 : 16'(scaled);
		end
	end

	fmqd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_i_q <= '0;
			prev_q_q <= '0;
			gain_q <= GAIN_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (gain_we) begin
				gain_q <= gain_data;
			end
			if (cmd.op == OP_MUL) begin
				prev_i_q <= cur_i_q;
				prev_q_q <= cur_q_q;
			end
			if (cmd.op == OP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				cur_i_q <= sample_i;
				cur_q_q <= sample_q;
			end
			OP_MUL: begin
				p_ii_q <= cur_i_q * prev_i_q;
				p_qq_q <= cur_q_q * prev_q_q;
				p_qi_q <= cur_q_q * prev_i_q;
				p_iq_q <= cur_i_q * prev_q_q;
			end
			OP_SUM: begin
				re_q <= 32'(p_ii_q + p_qq_q);
				im_q <= 32'(p_qi_q - p_iq_q);
			end
			OP_DIVX: begin
				x_sign_q <= im_q[31] ^ re_q[31];
			end
			OP_XSAT: begin
				x_mag_q <= (div_quo > {16'h0000, x_limit}) ? x_limit : div_quo[31:0];
				x_neg_q <= x_sign_q && (div_quo != '0);
			end
			OP_SQR: begin
				sq_q <= x_mag_q * x_mag_q;
			end
			OP_KX: begin
				kx_q <= sq_q[63:16] * ATAN_K_Q16;
			end
			OP_ANG: begin
				ang_mag_q <= div_quo[16:0];
				ang_neg_q <= x_neg_q;
			end
			OP_HALFPI: begin
				ang_mag_q <= HALF_PI_Q16;
				ang_neg_q <= im_q[31];
			end
			OP_SCALE: begin
				scl_q <= ang_mag_q * gain_q;
			end
			OP_OUT: begin
				out_data_q <= sat_val;
			end
			OP_NONE, OP_DIVA: begin
			end
			default: begin
			end
		endcase
	end

	assign status.re_zero = (re_q == '0);
	assign status.div_done = div_done;
	assign status.out_free = out_free;
	assign out_valid = out_valid_q;
	assign demod_value = out_data_q;

endmodule

FILE: hdl/fmqd_ctrl.sv
// ----------------------------------------------------------------------------
// FM quadrature discriminator controller
// Sequences one request through the datapath and the shared divider.
// ----------------------------------------------------------------------------
module fmqd_ctrl import fmqd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  fmqd_status_t status,
	output fmqd_cmd_t    cmd
);

	fmqd_state_t state_q;
	fmqd_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_MUL;
			ST_MUL:   state_d = ST_SUM;
			ST_SUM:   state_d = ST_CHK;
			ST_CHK:   state_d = status.re_zero ? ST_SCALE : ST_DIVX;
			ST_DIVX:  if (status.div_done) state_d = ST_XSAT;
			ST_XSAT:  state_d = ST_SQR;
			ST_SQR:   state_d = ST_KX;
			ST_KX:    state_d = ST_LDA;
			ST_LDA:   state_d = ST_DIVA;
			ST_DIVA:  if (status.div_done) state_d = ST_ANG;
			ST_ANG:   state_d = ST_SCALE;
			ST_SCALE: state_d = ST_OUT;
			ST_OUT:   if (status.out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.op = OP_NONE;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd.op = OP_LOAD;
			end
			ST_MUL:   cmd.op = OP_MUL;
			ST_SUM:   cmd.op = OP_SUM;
			ST_CHK:   cmd.op = status.re_zero ? OP_HALFPI : OP_DIVX;
			ST_DIVX:  cmd.op = OP_NONE;
			ST_XSAT:  cmd.op = OP_XSAT;
			ST_SQR:   cmd.op = OP_SQR;
			ST_KX:    cmd.op = OP_KX;
			ST_LDA:   cmd.op = OP_DIVA;
			ST_DIVA:  cmd.op = OP_NONE;
			ST_ANG:   cmd.op = OP_ANG;
			ST_SCALE: cmd.op = OP_SCALE;
			ST_OUT:   if (status.out_free) cmd.op = OP_OUT;
			default:  cmd.op = OP_NONE;
		endcase
	end

endmodule

FILE: hdl/fm_quadrature_discriminator_unit.sv
// ----------------------------------------------------------------------------
// FM quadrature discriminator unit
// Phase step between successive I/Q samples through a rational arctangent.
// ----------------------------------------------------------------------------
//  channel   modport  payload
//  samples   sink     sample_i, sample_q (signed 16)
//  result    source   demod_value (signed 16)
//  cfg       sink     output_gain (unsigned Q16.16)
//
// A request makes two passes through the shared one-bit-per-cycle divider, or none
// when the real part of the product is zero.
// Reset clears the previous sample to zero and the gain to 32767.0.
// A finished result waits in the output register while the next request is taken.
// A stalled result holds the next request's sequencer in its last state until it is taken.
// ----------------------------------------------------------------------------
module fm_quadrature_discriminator_unit import fmqd_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	fmqd_in_if.sink  samples,
	fmqd_out_if.source result,
	fmqd_cfg_if.sink cfg
);

	fmqd_cmd_t    cmd;
	fmqd_status_t status;

	assign cfg.ready = 1'b1;

	fmqd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.in_ready (samples.ready),
		.status   (status),
		.cmd      (cmd)
	);

	fmqd_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.sample_i    (samples.sample_i),
		.sample_q    (samples.sample_q),
		.gain_we     (cfg.valid),
		.gain_data   (cfg.output_gain),
		.out_ready   (result.ready),
		.out_valid   (result.valid),
		.demod_value (result.demod_value)
	);

endmodule
